@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/dcrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dcrt_pkg
// Types, codes and timing constants of the display controller.
// ----------------------------------------------------------------------------
package dcrt_pkg;

  // Access kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Bus event codes
  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_CANCEL_ACK = 4'd1;
  localparam logic [3:0] EV_BEEP       = 4'd2;
  localparam logic [3:0] EV_ATTENTION  = 4'd3;
  localparam logic [3:0] EV_CRT_ON     = 4'd4;
  localparam logic [3:0] EV_CRT_OFF    = 4'd5;
  localparam logic [3:0] EV_BUSY_CLR   = 4'd6;
  localparam logic [3:0] EV_BUSY_SET   = 4'd7;
  localparam logic [3:0] EV_VRAM_ON    = 4'd8;
  localparam logic [3:0] EV_VRAM_OFF   = 4'd9;
  localparam logic [3:0] EV_NMI_MASK   = 4'd10;

  // Register addresses
  localparam logic [15:0] ADDR_CANCEL  = 16'hd402;
  localparam logic [15:0] ADDR_BEEP    = 16'hd403;
  localparam logic [15:0] ADDR_ATTN    = 16'hd404;
  localparam logic [15:0] ADDR_CRT     = 16'hd408;
  localparam logic [15:0] ADDR_VRAM    = 16'hd409;
  localparam logic [15:0] ADDR_BUSY    = 16'hd40a;
  localparam logic [15:0] ADDR_OFS_HI  = 16'hd40e;
  localparam logic [15:0] ADDR_OFS_LO  = 16'hd40f;
  localparam logic [15:0] ADDR_MISC    = 16'hd430;

  localparam logic [7:0] OFS_LO_MASK = 8'he0;

  // Timing in microseconds
  localparam logic [14:0] VSYNC_ACTIVE_US = 15'd16130;
  localparam logic [14:0] VSYNC_PULSE_US  = 15'd510;
  localparam logic [14:0] VSYNC_RESET_US  = 15'd1520;
  localparam logic [11:0] VBLANK_US       = 12'd3940;
  localparam logic [11:0] HSYNC_US        = 12'd24;
  localparam logic [11:0] ACTIVE_US       = 12'd39;
  localparam logic [8:0]  LINES           = 9'd200;
  localparam logic [8:0]  LINE_RESET      = 9'd300;
  localparam logic [14:0] NMI_PERIOD_US   = 15'd20000;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
    logic        line_engine_busy;
    logic        sub_in_reset;
  } dcrt_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        claimed;
    logic [3:0]  bus_event;
    logic        scroll_valid;
    logic [15:0] scroll_delta;
    logic        scroll_page;
    logic        vsync_level;
    logic        blank_level;
    logic        nmi_pulse;
    logic        shown_page;
    logic        working_page;
    logic [1:0]  char_rom_bank;
  } dcrt_out_t;

endpackage

@@ rtl/display_controller_regs_and_timing.sv @@
// ----------------------------------------------------------------------------
// display_controller_regs_and_timing
// Display controller register decode, video timers and sub-CPU NMI timer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | dcrt_in_t (tick, read, write)
//  out_    | output    | out_valid/out_stall | dcrt_out_t (one per item)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data (advanced-model enable)
//
//  One item per cycle while the output is not stalled; each result appears in the cycle after its transfer.
//  Timers and registers update in the transfer cycle, the result goes to a
//  single output register. in_stall rises only while that register is full
//  and stalled. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module display_controller_regs_and_timing (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcrt_pkg::dcrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dcrt_pkg::dcrt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import dcrt_pkg::*;

  logic        is_av_r;
  logic        vsync_on_r,  vsync_on_nxt;
  logic [14:0] vsync_tmr_r, vsync_tmr_nxt;
  logic        blank_on_r,  blank_on_nxt;
  logic [11:0] blank_tmr_r, blank_tmr_nxt;
  logic [8:0]  line_cnt_r,  line_cnt_nxt;
  logic [14:0] nmi_tmr_r,   nmi_tmr_nxt;
  logic        nmi_en_r,    nmi_en_nxt;
  logic        crt_en_r,    crt_en_nxt;
  logic        vram_acc_r,  vram_acc_nxt;
  logic        ext_ofs_r,   ext_ofs_nxt;
  logic [3:0]  page_r,      page_nxt;
  logic [13:0] pend_r   [2];
  logic [13:0] pend_nxt [2];
  logic [13:0] cmt_r    [2];
  logic [13:0] cmt_nxt  [2];
  logic [1:0]  par_r,       par_nxt;
  logic        out_valid_r;
  dcrt_out_t   out_data_r;
  dcrt_out_t   res;
  logic        in_accept;
  logic        act_pg;
  logic [7:0]  lo_byte;
  logic [13:0] new_ofs;
  logic        ofs_wr;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign act_pg    = page_r[1];

  always_comb begin
    vsync_on_nxt  = vsync_on_r;
    vsync_tmr_nxt = vsync_tmr_r;
    blank_on_nxt  = blank_on_r;
    blank_tmr_nxt = blank_tmr_r;
    line_cnt_nxt  = line_cnt_r;
    nmi_tmr_nxt   = nmi_tmr_r;
    nmi_en_nxt    = nmi_en_r;
    crt_en_nxt    = crt_en_r;
    vram_acc_nxt  = vram_acc_r;
    ext_ofs_nxt   = ext_ofs_r;
    page_nxt      = page_r;
    pend_nxt      = pend_r;
    cmt_nxt       = cmt_r;
    par_nxt       = par_r;
    res           = '0;
    ofs_wr        = 1'b0;
    new_ofs       = pend_r[act_pg];
    lo_byte       = ext_ofs_r ? in_data.write_data : (in_data.write_data & OFS_LO_MASK);

    case (in_data.action)
      ACT_TICK: begin
        if (vsync_tmr_r <= 15'd1) begin
          vsync_on_nxt  = ~vsync_on_r;
          vsync_tmr_nxt = vsync_on_r ? VSYNC_ACTIVE_US : VSYNC_PULSE_US;
        end else begin
          vsync_tmr_nxt = vsync_tmr_r - 15'd1;
        end

        if (blank_tmr_r <= 12'd1) begin
          if (line_cnt_r >= LINES) begin
            blank_on_nxt = 1'b1;
            if (!blank_on_r) begin
              blank_tmr_nxt = VBLANK_US;
            end else begin
              blank_tmr_nxt = HSYNC_US;
              line_cnt_nxt  = '0;
            end
          end else if (blank_on_r) begin
            blank_on_nxt  = 1'b0;
            blank_tmr_nxt = ACTIVE_US + {11'd0, line_cnt_r[0]};
            line_cnt_nxt  = line_cnt_r + 9'd1;
          end else begin
            blank_on_nxt  = 1'b1;
            blank_tmr_nxt = HSYNC_US;
          end
        end else begin
          blank_tmr_nxt = blank_tmr_r - 12'd1;
        end

        if (nmi_en_r) begin
          if (nmi_tmr_r <= 15'd1) begin
            nmi_tmr_nxt   = NMI_PERIOD_US;
            res.nmi_pulse = 1'b1;
          end else begin
            nmi_tmr_nxt = nmi_tmr_r - 15'd1;
          end
        end
      end

      ACT_READ: begin
        case (in_data.bus_addr)
          ADDR_CANCEL: begin
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_CANCEL_ACK;
          end
          ADDR_BEEP: begin
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_BEEP;
          end
          ADDR_ATTN: begin
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_ATTENTION;
          end
          ADDR_CRT: begin
            crt_en_nxt = 1'b1;
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_CRT_ON;
          end
          ADDR_VRAM: begin
            vram_acc_nxt = 1'b1;
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_VRAM_ON;
          end
          ADDR_BUSY: begin
            res.read_data = 8'hff; res.claimed = 1'b1; res.bus_event = EV_BUSY_CLR;
          end
          ADDR_MISC: begin
            if (is_av_r) begin
              // Blank and busy status bits are active low; vsync and sub-CPU reset are active high
              res.read_data = {~blank_on_r, 2'b11, ~in_data.line_engine_busy, 1'b1,
                               vsync_on_r, 1'b1, in_data.sub_in_reset};
              res.claimed   = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ACT_WRITE: begin
        case (in_data.bus_addr)
          ADDR_CRT: begin
            crt_en_nxt = 1'b0;
            res.claimed = 1'b1; res.bus_event = EV_CRT_OFF;
          end
          ADDR_VRAM: begin
            vram_acc_nxt = 1'b0;
            res.claimed = 1'b1; res.bus_event = EV_VRAM_OFF;
          end
          ADDR_BUSY: begin
            res.claimed = 1'b1; res.bus_event = EV_BUSY_SET;
          end
          ADDR_OFS_HI: begin
            new_ofs = {in_data.write_data[5:0], pend_r[act_pg][7:0]};
            ofs_wr  = 1'b1;
            res.claimed = 1'b1;
          end
          ADDR_OFS_LO: begin
            new_ofs = {pend_r[act_pg][13:8], lo_byte};
            ofs_wr  = 1'b1;
            res.claimed = 1'b1;
          end
          ADDR_MISC: begin
            nmi_en_nxt  = ~in_data.write_data[7];
            if (in_data.write_data[7]) begin
              res.bus_event = EV_NMI_MASK;
            end
            page_nxt    = {in_data.write_data[1:0], in_data.write_data[5],
                           in_data.write_data[6]};
            ext_ofs_nxt = in_data.write_data[2];
            res.claimed = 1'b1;
          end
          default: begin
          end
        endcase
      end

      default: begin
      end
    endcase

    // Commit the pending offset on every second write to the page
    if (ofs_wr) begin
      pend_nxt[act_pg] = new_ofs;
      par_nxt[act_pg]  = ~par_r[act_pg];
      if (par_r[act_pg]) begin
        res.scroll_valid = 1'b1;
        res.scroll_delta = {2'b00, new_ofs} - {2'b00, cmt_r[act_pg]};
        res.scroll_page  = act_pg;
        cmt_nxt[act_pg]  = new_ofs;
      end
    end

    res.vsync_level   = vsync_on_nxt;
    res.blank_level   = blank_on_nxt;
    res.shown_page    = page_nxt[0];
    res.working_page  = page_nxt[1];
    res.char_rom_bank = page_nxt[3:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_av_r     <= 1'b1;
      vsync_on_r  <= 1'b0;
      vsync_tmr_r <= VSYNC_RESET_US;
      blank_on_r  <= 1'b1;
      blank_tmr_r <= VBLANK_US;
      line_cnt_r  <= LINE_RESET;
      nmi_tmr_r   <= NMI_PERIOD_US;
      nmi_en_r    <= 1'b1;
      crt_en_r    <= 1'b0;
      vram_acc_r  <= 1'b0;
      ext_ofs_r   <= 1'b0;
      page_r      <= '0;
      pend_r      <= '{default: '0};
      cmt_r       <= '{default: '0};
      par_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        is_av_r <= cfg_data;
      end
      if (in_accept) begin
        vsync_on_r  <= vsync_on_nxt;
        vsync_tmr_r <= vsync_tmr_nxt;
        blank_on_r  <= blank_on_nxt;
        blank_tmr_r <= blank_tmr_nxt;
        line_cnt_r  <= line_cnt_nxt;
        nmi_tmr_r   <= nmi_tmr_nxt;
        nmi_en_r    <= nmi_en_nxt;
        crt_en_r    <= crt_en_nxt;
        vram_acc_r  <= vram_acc_nxt;
        ext_ofs_r   <= ext_ofs_nxt;
        page_r      <= page_nxt;
        pend_r      <= pend_nxt;
        cmt_r       <= cmt_nxt;
        par_r       <= par_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

endmodule

@@ rtl/dcrt_checker.sv @@
// ----------------------------------------------------------------------------
// dcrt_checker
// Port-level checks of the display controller, bound into the controller module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcrt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input dcrt_pkg::dcrt_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input dcrt_pkg::dcrt_out_t out_data
);
  import dcrt_pkg::*;

  logic in_xfer;

  assign in_xfer  = in_valid && !in_stall;

  // Held result stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // Input backs up only behind a stalled result
  `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // Every tick transfer yields a result next cycle that touches no bus fields
  `ASSERT_NEXT(a_tick_quiet, clk, rst_n, in_xfer && in_data.action == ACT_TICK,
               out_valid && !out_data.claimed && out_data.read_data == 8'd0
               && out_data.bus_event == EV_NONE)

  // Writes never return data or fire NMI
  `ASSERT_NEXT(a_write_quiet, clk, rst_n, in_xfer && in_data.action == ACT_WRITE,
               out_valid && out_data.read_data == 8'd0 && !out_data.nmi_pulse)

  // Scroll fields are zero unless a scroll is reported
  `ASSERT_SAME(a_scroll_zero, clk, rst_n, out_valid && !out_data.scroll_valid,
               out_data.scroll_delta == 16'd0 && !out_data.scroll_page)

endmodule

bind display_controller_regs_and_timing dcrt_checker u_dcrt_checker (.*);

@@ tb/sv/dcrt_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// dcrt_tb_pkg
// Response tracker for the display controller testbench: mirrors the
// controller's timers and registers, predicts one response per transfer
// and compares each returned response against the oldest prediction.
// ----------------------------------------------------------------------------
package dcrt_tb_pkg;

  import dcrt_pkg::*;

  class dcrt_response_tracker;

    // mirrored controller state
    bit          av_model;
    bit          vsync_on;
    logic [14:0] vsync_timer;
    bit          blank_on;
    logic [11:0] blank_timer;
    logic [8:0]  line_count;
    logic [14:0] nmi_timer;
    bit          nmi_enabled;
    bit          crt_enabled;
    bit          vram_access;
    bit          ext_offset;
    bit          shown_pg;
    bit          work_pg;
    logic [1:0]  rom_bank;
    logic [13:0] pend_ofs[2];
    logic [13:0] comm_ofs[2];
    bit          ofs_parity[2];

    dcrt_out_t   pending_responses[$];
    int          mismatches;

    function new();
      av_model    = 1'b1;
      vsync_on    = 1'b0;
      vsync_timer = VSYNC_RESET_US;
      blank_on    = 1'b1;
      blank_timer = VBLANK_US;
      line_count  = LINE_RESET;
      nmi_timer   = NMI_PERIOD_US;
      nmi_enabled = 1'b1;
      crt_enabled = 1'b0;
      vram_access = 1'b0;
      ext_offset  = 1'b0;
      shown_pg    = 1'b0;
      work_pg     = 1'b0;
      rom_bank    = 2'd0;
      for (int p = 0; p < 2; p++) begin
        pend_ofs[p]   = '0;
        comm_ofs[p]   = '0;
        ofs_parity[p] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void set_model(bit v);
      av_model = v;
    endfunction

    // every second offset write on a page commits the pending offset
    function void commit_offset(bit pg, inout dcrt_out_t r);
      ofs_parity[pg] = !ofs_parity[pg];
      if (!ofs_parity[pg]) begin
        r.scroll_valid = 1'b1;
        r.scroll_delta = {2'b00, pend_ofs[pg]} - {2'b00, comm_ofs[pg]};
        r.scroll_page  = pg;
        comm_ofs[pg]   = pend_ofs[pg];
      end
    endfunction

    function dcrt_out_t predict_response(dcrt_in_t it);
      dcrt_out_t  r;
      bit         pg;
      logic [7:0] d;
      r  = '0;
      pg = work_pg;
      d  = it.write_data;
      case (it.action)
        ACT_TICK: begin
          if (vsync_timer <= 15'd1) begin
            vsync_on    = !vsync_on;
            vsync_timer = vsync_on ? VSYNC_PULSE_US : VSYNC_ACTIVE_US;
          end else begin
            vsync_timer--;
          end
          if (blank_timer <= 12'd1) begin
            if (line_count >= LINES) begin
              if (!blank_on) begin
                blank_on    = 1'b1;
                blank_timer = VBLANK_US;
              end else begin
                blank_timer = HSYNC_US;
                line_count  = '0;
              end
            end else if (blank_on) begin
              // active width alternates with line parity
              blank_on    = 1'b0;
              blank_timer = ACTIVE_US + {11'd0, line_count[0]};
              line_count  = line_count + 9'd1;
            end else begin
              blank_on    = 1'b1;
              blank_timer = HSYNC_US;
            end
          end else begin
            blank_timer--;
          end
          if (nmi_enabled) begin
            if (nmi_timer <= 15'd1) begin
              nmi_timer   = NMI_PERIOD_US;
              r.nmi_pulse = 1'b1;
            end else begin
              nmi_timer--;
            end
          end
        end
        ACT_READ: begin
          case (it.bus_addr)
            ADDR_CANCEL: r.bus_event = EV_CANCEL_ACK;
            ADDR_BEEP:   r.bus_event = EV_BEEP;
            ADDR_ATTN:   r.bus_event = EV_ATTENTION;
            ADDR_CRT: begin
              crt_enabled = 1'b1;
              r.bus_event = EV_CRT_ON;
            end
            ADDR_VRAM: begin
              vram_access = 1'b1;
              r.bus_event = EV_VRAM_ON;
            end
            ADDR_BUSY:   r.bus_event = EV_BUSY_CLR;
            ADDR_MISC: begin
              if (av_model) begin
                r.claimed   = 1'b1;
                r.read_data = 8'hff;
                if (blank_on) r.read_data[7] = 1'b0;
                if (it.line_engine_busy) r.read_data[4] = 1'b0;
                if (!vsync_on) r.read_data[2] = 1'b0;
                if (!it.sub_in_reset) r.read_data[0] = 1'b0;
              end
            end
            default: ;
          endcase
          // strobe reads all return all ones
          if (r.bus_event != EV_NONE) begin
            r.read_data = 8'hff;
            r.claimed   = 1'b1;
          end
        end
        ACT_WRITE: begin
          case (it.bus_addr)
            ADDR_CRT: begin
              crt_enabled = 1'b0;
              r.claimed   = 1'b1;
              r.bus_event = EV_CRT_OFF;
            end
            ADDR_VRAM: begin
              vram_access = 1'b0;
              r.claimed   = 1'b1;
              r.bus_event = EV_VRAM_OFF;
            end
            ADDR_BUSY: begin
              r.claimed   = 1'b1;
              r.bus_event = EV_BUSY_SET;
            end
            ADDR_OFS_HI: begin
              pend_ofs[pg] = {d[5:0], pend_ofs[pg][7:0]};
              commit_offset(pg, r);
              r.claimed = 1'b1;
            end
            ADDR_OFS_LO: begin
              if (!ext_offset) d = d & OFS_LO_MASK;
              pend_ofs[pg] = {pend_ofs[pg][13:8], d};
              commit_offset(pg, r);
              r.claimed = 1'b1;
            end
            ADDR_MISC: begin
              nmi_enabled = !d[7];
              if (d[7]) r.bus_event = EV_NMI_MASK;
              shown_pg   = d[6];
              work_pg    = d[5];
              rom_bank   = d[1:0];
              ext_offset = d[2];
              r.claimed  = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.vsync_level   = vsync_on;
      r.blank_level   = blank_on;
      r.shown_page    = shown_pg;
      r.working_page  = work_pg;
      r.char_rom_bank = rom_bank;
      return r;
    endfunction

    function void note_access(dcrt_in_t it);
      pending_responses.push_back(predict_response(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(dcrt_out_t got);
      dcrt_out_t want;
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response %h arrived with no transfer outstanding", got);
        return;
      end
      want = pending_responses.pop_front();
      compare_field("read_data",     16'(want.read_data),     16'(got.read_data));
      compare_field("claimed",       16'(want.claimed),       16'(got.claimed));
      compare_field("bus_event",     16'(want.bus_event),     16'(got.bus_event));
      compare_field("scroll_valid",  16'(want.scroll_valid),  16'(got.scroll_valid));
      compare_field("scroll_delta",  want.scroll_delta,       got.scroll_delta);
      compare_field("scroll_page",   16'(want.scroll_page),   16'(got.scroll_page));
      compare_field("vsync_level",   16'(want.vsync_level),   16'(got.vsync_level));
      compare_field("blank_level",   16'(want.blank_level),   16'(got.blank_level));
      compare_field("nmi_pulse",     16'(want.nmi_pulse),     16'(got.nmi_pulse));
      compare_field("shown_page",    16'(want.shown_page),    16'(got.shown_page));
      compare_field("working_page",  16'(want.working_page),  16'(got.working_page));
      compare_field("char_rom_bank", 16'(want.char_rom_bank), 16'(got.char_rom_bank));
    endfunction

  endclass

endpackage

@@ tb/sv/display_controller_regs_and_timing_tb.sv @@
// ----------------------------------------------------------------------------
// display_controller_regs_and_timing_tb
// Drives ticks, register reads and writes into the display controller with
// random idle cycles and back-pressure, and checks every response against a
// cycle-free model of the timers and registers under both model settings.
// ----------------------------------------------------------------------------
module display_controller_regs_and_timing_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dcrt_pkg::*;
  import dcrt_tb_pkg::*;

  localparam logic [1:0] ACT_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SWEEP_TICKS = 200;
  localparam int         RANDOM_HALF = 215;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  dcrt_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  dcrt_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  dcrt_response_tracker sb;

  int sent       = 0;
  bit in_calm    = 1'b0;
  bit out_calm   = 1'b0;
  bit press_go   = 1'b0;
  bit press_done = 1'b0;
  int hold_left  = 0;

  display_controller_regs_and_timing DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // response side: check each transfer, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (press_go && !press_done) begin
      hold_left  = 80;
      press_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !out_calm && ($urandom_range(99) < 22);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  function automatic dcrt_in_t mk(logic [1:0] act, logic [15:0] addr, logic [7:0] data);
    dcrt_in_t it;
    it.action           = act;
    it.bus_addr         = addr;
    it.write_data       = data;
    it.line_engine_busy = 1'($urandom_range(1));
    it.sub_in_reset     = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic logic [15:0] pick_reg_addr();
    case ($urandom_range(8))
      0:       return ADDR_CANCEL;
      1:       return ADDR_BEEP;
      2:       return ADDR_ATTN;
      3:       return ADDR_CRT;
      4:       return ADDR_VRAM;
      5:       return ADDR_BUSY;
      6:       return ADDR_OFS_HI;
      7:       return ADDR_OFS_LO;
      default: return ADDR_MISC;
    endcase
  endfunction

  task automatic send_access(dcrt_in_t it);
    if (!in_calm) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_access(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_model(bit v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_model(v);
  endtask

  task automatic random_episode(bit allow_mask);
    int         pick;
    int         n;
    logic [7:0] d;
    logic [1:0] act;
    logic [15:0] addr;
    pick = $urandom_range(99);
    d    = 8'($urandom);
    if (!allow_mask || $urandom_range(9) != 0) d[7] = 1'b0;
    if (pick < 30) begin
      // scroll: optional page select, then an offset pair
      if ($urandom_range(1)) send_access(mk(ACT_WRITE, ADDR_MISC, d));
      send_access(mk(ACT_WRITE, ADDR_OFS_HI, 8'($urandom)));
      send_access(mk(ACT_WRITE, ADDR_OFS_LO, 8'($urandom)));
    end else if (pick < 55) begin
      n = $urandom_range(1, 8);
      repeat (n) send_access(mk(ACT_TICK, 16'($urandom), 8'($urandom)));
    end else if (pick < 75) begin
      act  = 2'($urandom_range(1, 2));
      addr = pick_reg_addr();
      send_access(mk(act, addr, d));
    end else if (pick < 85) begin
      send_access(mk(ACT_READ, ADDR_MISC, 8'($urandom)));
    end else begin
      send_access(mk(2'($urandom_range(3)), 16'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    dcrt_in_t it;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_model(1'b1);

    // status read with both input-driven status bits driven both ways
    it = mk(ACT_READ, ADDR_MISC, 8'h00);
    it.line_engine_busy = 1'b1;
    it.sub_in_reset     = 1'b0;
    send_access(it);
    it = mk(ACT_READ, ADDR_MISC, 8'hff);
    it.line_engine_busy = 1'b0;
    it.sub_in_reset     = 1'b1;
    send_access(it);
    send_access(mk(ACT_READ, ADDR_CANCEL, 8'h00));
    send_access(mk(ACT_READ, ADDR_BEEP, 8'h00));
    send_access(mk(ACT_READ, ADDR_ATTN, 8'h00));
    send_access(mk(ACT_READ, ADDR_CRT, 8'h00));
    send_access(mk(ACT_READ, ADDR_CRT, 8'h00));
    send_access(mk(ACT_READ, ADDR_VRAM, 8'h00));
    send_access(mk(ACT_READ, ADDR_BUSY, 8'h00));
    send_access(mk(ACT_WRITE, ADDR_CRT, 8'h00));
    send_access(mk(ACT_WRITE, ADDR_VRAM, 8'hff));
    send_access(mk(ACT_WRITE, ADDR_BUSY, 8'h00));
    // low byte loses its low five bits without extended mode
    send_access(mk(ACT_WRITE, ADDR_OFS_LO, 8'hff));
    send_access(mk(ACT_WRITE, ADDR_OFS_HI, 8'hff));
    // mask NMI, select page 1, extended offsets, bank 3
    send_access(mk(ACT_WRITE, ADDR_MISC, 8'he7));
    send_access(mk(ACT_TICK, 16'h0000, 8'h00));
    send_access(mk(ACT_WRITE, ADDR_OFS_HI, 8'hc5));
    send_access(mk(ACT_WRITE, ADDR_OFS_LO, 8'hff));
    send_access(mk(ACT_WRITE, ADDR_MISC, 8'h00));
    send_access(mk(ACT_SPARE, 16'hffff, 8'hff));
    send_access(mk(ACT_READ, 16'h0000, 8'h00));
    send_access(mk(ACT_WRITE, 16'hffff, 8'hff));
    send_access(mk(ACT_TICK, 16'hffff, 8'hff));

    // basic model: status reads go unclaimed
    write_model(1'b0);
    sent = 0;
    while (sent < RANDOM_HALF) random_episode(1'b1);

    // tick-heavy run: gap-free at first, then a long receiver hold-off
    write_model(1'b1);
    sent     = 0;
    in_calm  = 1'b1;
    out_calm = 1'b1;
    while (sent < SWEEP_TICKS) begin
      if (sent >= 60) begin
        in_calm  = 1'b0;
        out_calm = 1'b0;
      end
      if (sent >= 100) press_go = 1'b1;
      if ($urandom_range(99) < 97)
        send_access(mk(ACT_TICK, 16'($urandom), 8'($urandom)));
      else
        random_episode(1'b0);
    end

    sent = 0;
    while (sent < RANDOM_HALF) random_episode(1'b1);

    drain();
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_responses.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ display_controller_regs_and_timing.f @@
+incdir+rtl
rtl/dcrt_pkg.sv
rtl/display_controller_regs_and_timing.sv
rtl/dcrt_checker.sv
tb/sv/dcrt_tb_pkg.sv
tb/sv/display_controller_regs_and_timing_tb.sv
